[hdl/mrc_pkg.sv]
// mrc_pkg: shared types, constants and crc-32 helpers for the memory region crc checker
// no dependencies; imported by every module of the block

package mrc_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 27;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_PASS = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED_CRC = 1'b0,
    REG_REGION_WORDS = 1'b1
  } cfg_reg_t;

  // one word held between the input register and the crc core
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
  } mrc_item_t;

  typedef logic [WORD_W-1:0][WORD_W-1:0] crc_cols_t;

  // 32 reflected shift steps of a single value, used only at elaboration
  function automatic logic [WORD_W-1:0] crc_shift32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] c;
    c = v;
    for (int b = 0; b < WORD_W; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic crc_cols_t crc_cols_init();
    crc_cols_t cols;
    for (int j = 0; j < WORD_W; j++) begin
      cols[j] = crc_shift32(WORD_W'(1) << j);
    end
    return cols;
  endfunction

  // column j is the crc after a whole word when only bit j of (crc ^ word) is set
  localparam crc_cols_t CRC_COLS = crc_cols_init();

  // four bytes lsb first equal one xor of the full word followed by 32 shifts
  function automatic logic [WORD_W-1:0] crc32_word(input logic [WORD_W-1:0] crc,
                                                   input logic [WORD_W-1:0] data);
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] acc;
    x   = crc ^ data;
    acc = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (x[j]) begin
        acc = acc ^ CRC_COLS[j];
      end
    end
    return acc;
  endfunction

endpackage

[hdl/memory_region_crc_checker.sv]
// memory_region_crc_checker: top level of the region crc-32 integrity checker
// depends on mrc_pkg, mrc_in_stage and mrc_core
//
//   channel | ports                                     | direction
//   input   | in_valid, in_stall, in_data_word          | one memory word per item
//   result  | out_valid, out_stall, out_check_status,   | one status item per word
//           | out_pass_done                             |
//   config  | cfg_we, cfg_index, cfg_data               | expected crc, region size
//
// an item is registered at the input, then the parallel 32-bit crc update and the end-of-pass
// compare run from the input register into the result register; one item per cycle is
// sustained while the result is not stalled, carried by the combinational crc update loop
// synchronous reset clears the running crc to all ones, the count to zero, status to busy
// a stalled result holds its register; the input stalls only when both registers are full

module memory_region_crc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mrc_pkg::WORD_W-1:0]    in_data_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_check_status,
  output logic                          out_pass_done,
  input  logic                          cfg_we,
  input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrc_pkg::WORD_W-1:0]    cfg_data
);
  import mrc_pkg::*;

  mrc_item_t item;
  logic      take;

  mrc_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_word (in_data_word),
    .take         (take),
    .item         (item)
  );

  mrc_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item             (item),
    .take             (take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_check_status (out_check_status),
    .out_pass_done    (out_pass_done)
  );

  // a finished pass always leaves pass or fail behind
  a_done_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pass_done |-> out_check_status != ST_BUSY)
    else $error("pass completed with busy status");

  // fail is sticky until reset
  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_check_status == ST_FAIL |=> !out_valid || out_check_status == ST_FAIL)
    else $error("fail status was cleared");

  // the input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

endmodule

[hdl/mrc_in_stage.sv]
// mrc_in_stage: input register of the crc checker, holds one item for the core
// depends on mrc_pkg

module mrc_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mrc_pkg::WORD_W-1:0] in_data_word,
  input  logic                       take,
  output mrc_pkg::mrc_item_t         item
);
  import mrc_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [WORD_W-1:0] word_r;
  logic              load;

  // stall only while a held item cannot move on
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_data_word;
    end
  end

  assign item.valid = valid_r;
  assign item.word  = word_r;

endmodule

[hdl/mrc_core.sv]
// mrc_core: configuration registers, running crc, word count, status and result register
// depends on mrc_pkg

module mrc_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrc_pkg::WORD_W-1:0]    cfg_data,
  input  mrc_pkg::mrc_item_t            item,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_check_status,
  output logic                          out_pass_done
);
  import mrc_pkg::*;

  logic [WORD_W-1:0]  expected_r;
  logic [COUNT_W-1:0] region_r;
  logic [WORD_W-1:0]  crc_r;
  logic [WORD_W-1:0]  crc_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  status_t            status_r;
  status_t            status_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               done_r;
  logic [WORD_W-1:0]  crc_upd;
  logic [COUNT_W:0]   count_inc;
  logic               done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      region_r   <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_EXPECTED_CRC: expected_r <= cfg_data;
        REG_REGION_WORDS: region_r   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign take      = item.valid && (!out_valid_r || !out_stall);
  assign crc_upd   = crc32_word(crc_r, item.word);
  // one bit wider so the last count value still completes a pass
  assign count_inc = {1'b0, count_r} + (COUNT_W+1)'(1);
  assign done      = count_inc >= {1'b0, region_r};

  always_comb begin
    crc_nxt    = crc_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (take) begin
      if (done) begin
        crc_nxt   = CRC_INIT;
        count_nxt = '0;
        if ((crc_upd ^ CRC_INIT) != expected_r) begin
          status_nxt = ST_FAIL;
        end else if (status_r != ST_FAIL) begin
          status_nxt = ST_PASS;
        end
      end else begin
        crc_nxt   = crc_upd;
        count_nxt = count_inc[COUNT_W-1:0];
      end
    end
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      count_r     <= '0;
      status_r    <= ST_BUSY;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      done_r <= done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_check_status = status_r;
  assign out_pass_done    = done_r;

endmodule
